>>> design/gsfc_pkg.sv
// shared types and codes for the go/stop flow control node
package gsfc_pkg;

   typedef enum logic [2:0] {
      REQ_ENQUEUE  = 3'd0,
      REQ_DATA_RX  = 3'd1,
      REQ_ACK_RX   = 3'd2,
      REQ_TICK     = 3'd3,
      REQ_TX_SLOT  = 3'd4
   } req_kind_type;

   typedef enum logic [2:0] {
      OUT_NONE     = 3'd0,
      OUT_ENQUEUED = 3'd1,
      OUT_FULL     = 3'd2,
      OUT_DATA     = 3'd3,
      OUT_GO       = 3'd4,
      OUT_STOP     = 3'd5,
      OUT_DISCARD  = 3'd6
   } out_kind_type;

   localparam logic ACK_GO = 1'b0;

   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_COUNT   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RESUME_DELAY = 8'd1;

   localparam int HANDLE_W = 16;
   localparam int TALLY_W  = 8;
   localparam int TIMER_W  = 16;
   localparam int CSR_DATA_W = 16;

   localparam logic [TALLY_W-1:0] STOP_COUNT_RESET   = 8'd2;
   localparam logic [TIMER_W-1:0] RESUME_DELAY_RESET = 16'd2000;

endpackage

>>> design/go_stop_flow_control_node_unit.sv
// go/stop stop-and-wait flow control node: send ring, permits, receive tally and resume timer
// the result item of an accepted request item is registered in the output register
// throughput: one item per cycle; a new item is taken whenever the output register is empty
// or its item is taken in the same cycle; the ring read is one registered memory port
// reset (synchronous, active high): ring empty, both permits set, tally and timer cleared,
// stop count 2, resume delay 2000; ring contents are left as they are
module go_stop_flow_control_node_unit #(
   parameter int RING_DEPTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [15:0] req_tdata,  // msg_handle
   input  logic [3:0] req_tuser,   // req_type [2:0], ack_kind [3]
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // out_handle, queue_fill, may_send, may_receive, zero fill
   output logic [(((gsfc_pkg::HANDLE_W + $clog2(RING_DEPTH + 1) + 2) + 7) / 8) * 8 - 1:0]
                rsp_tdata,
   output logic [2:0] rsp_tuser,   // out_kind
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [gsfc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [gsfc_pkg::CSR_DATA_W-1:0] csr_data
);
   import gsfc_pkg::*;

   localparam int HEAD_W = $clog2(RING_DEPTH);
   localparam int CNT_W  = $clog2(RING_DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int PAY_W  = HANDLE_W + CNT_W + 2;
   localparam int RSP_W  = ((PAY_W + 7) / 8) * 8;

   logic [HANDLE_W-1:0] ring_mem [RING_DEPTH];

   logic [HEAD_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic send_permit_ff, send_permit_in;
   logic recv_permit_ff, recv_permit_in;
   logic [TALLY_W-1:0] tally_ff, tally_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic timer_run_ff, timer_run_in;
   logic [TALLY_W-1:0] stop_count_ff;
   logic [TIMER_W-1:0] resume_delay_ff;

   logic rsp_valid_ff;
   out_kind_type kind_ff, kind_in;
   logic [CNT_W-1:0] fill_ff;
   logic may_send_ff, may_recv_ff;
   logic sent_ff;
   logic [HANDLE_W-1:0] rd_data_ff;

   logic accept;
   req_kind_type req_kind;
   logic ack_kind;
   logic [HANDLE_W-1:0] msg_handle;
   logic [SUM_W-1:0] tail_sum;
   logic [HEAD_W-1:0] tail;
   logic ring_full;
   logic ring_write;
   logic ring_read;
   logic [TALLY_W-1:0] tally_inc;

   assign req_kind   = req_kind_type'(req_tuser[2:0]);
   assign ack_kind   = req_tuser[3];
   assign msg_handle = req_tdata;

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;
   assign csr_ready  = 1'b1;

   assign ring_full = (count_ff >= CNT_W'(RING_DEPTH));
   assign tally_inc = (tally_ff == {TALLY_W{1'b1}}) ? tally_ff : tally_ff + 1'b1;

   always_comb begin
      tail_sum = SUM_W'(head_ff) + SUM_W'(count_ff);
      if (tail_sum >= SUM_W'(RING_DEPTH)) begin
         tail_sum = tail_sum - SUM_W'(RING_DEPTH);
      end
      tail = tail_sum[HEAD_W-1:0];
   end

   always_comb begin
      head_in        = head_ff;
      count_in       = count_ff;
      send_permit_in = send_permit_ff;
      recv_permit_in = recv_permit_ff;
      tally_in       = tally_ff;
      timer_in       = timer_ff;
      timer_run_in   = timer_run_ff;
      kind_in        = OUT_NONE;
      ring_write     = 1'b0;
      ring_read      = 1'b0;
      case (req_kind)
         REQ_ENQUEUE: begin
            if (ring_full) begin
               kind_in = OUT_FULL;
            end else begin
               ring_write = 1'b1;
               count_in   = count_ff + 1'b1;
               kind_in    = OUT_ENQUEUED;
            end
         end
         REQ_DATA_RX: begin
            if (recv_permit_ff) begin
               tally_in = tally_inc;
               if (tally_inc >= stop_count_ff) begin
                  recv_permit_in = 1'b0;
                  timer_in       = resume_delay_ff;
                  timer_run_in   = 1'b1;
                  kind_in        = OUT_STOP;
               end else begin
                  kind_in = OUT_GO;
               end
            end else begin
               kind_in = OUT_DISCARD;
            end
         end
         REQ_ACK_RX: begin
            send_permit_in = (ack_kind == ACK_GO);
         end
         REQ_TICK: begin
            if (timer_run_ff) begin
               if (timer_ff <= TIMER_W'(1)) begin
                  timer_in       = '0;
                  timer_run_in   = 1'b0;
                  recv_permit_in = 1'b1;
                  tally_in       = '0;
                  kind_in        = OUT_GO;
               end else begin
                  timer_in = timer_ff - 1'b1;
               end
            end
         end
         REQ_TX_SLOT: begin
            if (send_permit_ff && (count_ff != '0)) begin
               ring_read      = 1'b1;
               head_in        = (head_ff == HEAD_W'(RING_DEPTH - 1)) ? '0 : head_ff + 1'b1;
               count_in       = count_ff - 1'b1;
               send_permit_in = 1'b0;
               kind_in        = OUT_DATA;
            end
         end
         default: begin
            kind_in = OUT_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept && ring_write) begin
         ring_mem[tail] <= msg_handle;
      end
      if (accept && ring_read) begin
         rd_data_ff <= ring_mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff        <= '0;
         count_ff       <= '0;
         send_permit_ff <= 1'b1;
         recv_permit_ff <= 1'b1;
         tally_ff       <= '0;
         timer_ff       <= '0;
         timer_run_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            head_ff        <= head_in;
            count_ff       <= count_in;
            send_permit_ff <= send_permit_in;
            recv_permit_ff <= recv_permit_in;
            tally_ff       <= tally_in;
            timer_ff       <= timer_in;
            timer_run_ff   <= timer_run_in;
            rsp_valid_ff   <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff   <= STOP_COUNT_RESET;
         resume_delay_ff <= RESUME_DELAY_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STOP_COUNT: begin
               stop_count_ff <= csr_data[TALLY_W-1:0];
            end
            CSR_RESUME_DELAY: begin
               resume_delay_ff <= csr_data[TIMER_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff     <= kind_in;
         fill_ff     <= count_in;
         may_send_ff <= send_permit_in;
         may_recv_ff <= recv_permit_in;
         sent_ff     <= ring_read;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = RSP_W'({may_recv_ff, may_send_ff, fill_ff,
                               (sent_ff ? rd_data_ff : {HANDLE_W{1'b0}})});

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RING_DEPTH))
      else $error("ring count beyond depth");

   a_blocked_has_timer: assert property (@(posedge clock) disable iff (reset)
      !recv_permit_ff |-> timer_run_ff)
      else $error("reception blocked with no resume timer running");

   a_stop_blocks: assert property (@(posedge clock) disable iff (reset)
      accept && kind_in == OUT_STOP |=> !recv_permit_ff && !may_recv_ff)
      else $error("stop answer left reception open");

   a_data_clears_permit: assert property (@(posedge clock) disable iff (reset)
      accept && kind_in == OUT_DATA |=> !send_permit_ff && sent_ff)
      else $error("send permission kept after sending data");

endmodule

>>> sim/go_stop_flow_control_node_unit_tb.sv
// self-checking testbench for the go/stop flow control node: directed table, then random phases
module go_stop_flow_control_node_unit_tb;
   import gsfc_pkg::*;

   localparam int DEPTH = 16;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int RSP_W = ((HANDLE_W + FILL_W + 2 + 7) / 8) * 8;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 4;
   localparam int PRESSURE_CYCLES = 60;
   localparam int PRESSURE_AFTER = 150;
   localparam logic [2:0] REQ_SPARE_A = 3'd5;
   localparam logic [2:0] REQ_SPARE_B = 3'd6;
   localparam logic [2:0] REQ_SPARE_C = 3'd7;
   localparam logic ACK_STOP = ~ACK_GO;
   localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

   typedef struct packed {
      out_kind_type kind;
      logic [HANDLE_W-1:0] handle;
      logic [FILL_W-1:0] fill;
      logic may_send;
      logic may_receive;
   } node_reply_type;

   typedef struct {
      bit is_csr;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [2:0] op;
      logic [HANDLE_W-1:0] handle;
      logic ack;
      int reps;
      bit typed;
      node_reply_type reply;
   } stim_row_type;

   typedef struct {
      int stop;
      int delay;
      int items;
      int c_enq;
      int c_data;
      int c_ack;
      int c_tick;
      int c_tx;
      bit jitter;
   } phase_mix_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [HANDLE_W-1:0] req_tdata = '0;   // msg_handle
   logic [3:0] req_tuser = '0;            // req_type [2:0], ack_kind [3]
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;           // out_handle, queue_fill, may_send, may_receive, zero fill
   logic [2:0] rsp_tuser;                 // out_kind
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // node state as the testbench sees it
   logic [HANDLE_W-1:0] ring_copy [DEPTH];
   logic [PTR_W-1:0] ring_first = '0;
   logic [FILL_W-1:0] ring_used = '0;
   logic tx_permit = 1'b1;
   logic rx_open = 1'b1;
   logic [TALLY_W-1:0] rx_tally = '0;
   logic [TIMER_W-1:0] resume_left = '0;
   logic timer_on = 1'b0;
   logic [TALLY_W-1:0] stop_count = STOP_COUNT_RESET;
   logic [TIMER_W-1:0] resume_delay = RESUME_DELAY_RESET;

   node_reply_type awaited_replies [$];
   stim_row_type directed_plan [$];
   phase_mix_type random_phases [$];
   int fault_count = 0;
   int replies_seen = 0;
   bit tx_jitter = 1'b1;
   bit rx_jitter = 1'b1;
   bit pressure_done = 1'b0;

   go_stop_flow_control_node_unit #(
      .RING_DEPTH(DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic node_reply_type step_flow_node(logic [2:0] op,
                                                     logic [HANDLE_W-1:0] handle,
                                                     logic ack);
      node_reply_type r;
      r.kind = OUT_NONE;
      r.handle = '0;
      case (op)
         REQ_ENQUEUE: begin
            if (ring_used >= DEPTH) begin
               r.kind = OUT_FULL;
            end else begin
               ring_copy[ring_first + ring_used[PTR_W-1:0]] = handle;
               ring_used = ring_used + 1'b1;
               r.kind = OUT_ENQUEUED;
            end
         end
         REQ_DATA_RX: begin
            if (rx_open) begin
               if (rx_tally != TALLY_MAX) rx_tally = rx_tally + 1'b1;
               if (rx_tally >= stop_count) begin
                  rx_open = 1'b0;
                  resume_left = resume_delay;
                  timer_on = 1'b1;
                  r.kind = OUT_STOP;
               end else begin
                  r.kind = OUT_GO;
               end
            end else begin
               r.kind = OUT_DISCARD;
            end
         end
         REQ_ACK_RX: tx_permit = (ack == ACK_GO);
         REQ_TICK: begin
            if (timer_on) begin
               if (resume_left <= 1) begin
                  resume_left = '0;
                  timer_on = 1'b0;
                  rx_open = 1'b1;
                  rx_tally = '0;
                  r.kind = OUT_GO;
               end else begin
                  resume_left = resume_left - 1'b1;
               end
            end
         end
         REQ_TX_SLOT: begin
            if (tx_permit && ring_used != 0) begin
               r.handle = ring_copy[ring_first];
               ring_first = ring_first + 1'b1;
               ring_used = ring_used - 1'b1;
               tx_permit = 1'b0;
               r.kind = OUT_DATA;
            end
         end
         default: ;
      endcase
      r.fill = ring_used;
      r.may_send = tx_permit;
      r.may_receive = rx_open;
      return r;
   endfunction

   function automatic stim_row_type item_row(logic [2:0] op, logic [HANDLE_W-1:0] handle,
                                             logic ack, int reps);
      stim_row_type s;
      s.is_csr = 1'b0;
      s.reg_index = '0;
      s.op = op;
      s.handle = handle;
      s.ack = ack;
      s.reps = reps;
      s.typed = 1'b0;
      s.reply = '0;
      return s;
   endfunction

   function automatic stim_row_type typed_row(logic [2:0] op, logic [HANDLE_W-1:0] handle,
                                              logic ack, out_kind_type kind,
                                              logic [HANDLE_W-1:0] sent, int fill,
                                              logic snd, logic rcv);
      stim_row_type s;
      s = item_row(op, handle, ack, 1);
      s.typed = 1'b1;
      s.reply.kind = kind;
      s.reply.handle = sent;
      s.reply.fill = FILL_W'(fill);
      s.reply.may_send = snd;
      s.reply.may_receive = rcv;
      return s;
   endfunction

   function automatic stim_row_type csr_row(logic [CSR_INDEX_W-1:0] idx,
                                            logic [CSR_DATA_W-1:0] value);
      stim_row_type s;
      s = item_row(REQ_ENQUEUE, value, ACK_GO, 1);
      s.is_csr = 1'b1;
      s.reg_index = idx;
      return s;
   endfunction

   task automatic offer_item(logic [2:0] op, logic [HANDLE_W-1:0] handle, logic ack,
                             bit typed, node_reply_type typed_reply);
      node_reply_type predicted;
      if (tx_jitter && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= handle;
      req_tuser <= {ack, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = step_flow_node(op, handle, ack);
      awaited_replies.push_back(typed ? typed_reply : predicted);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      req_tvalid <= 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_STOP_COUNT) stop_count = value[TALLY_W-1:0];
      else if (idx == CSR_RESUME_DELAY) resume_delay = value[TIMER_W-1:0];
      @(posedge clock);
   endtask

   task automatic run_phase(phase_mix_type m);
      int roll;
      logic [2:0] op;
      logic ack;
      write_reg(CSR_STOP_COUNT, CSR_DATA_W'(m.stop));
      write_reg(CSR_RESUME_DELAY, CSR_DATA_W'(m.delay));
      tx_jitter = m.jitter;
      rx_jitter = m.jitter;
      repeat (m.items) begin
         roll = $urandom_range(0, 99);
         if (roll < m.c_enq) op = REQ_ENQUEUE;
         else if (roll < m.c_data) op = REQ_DATA_RX;
         else if (roll < m.c_ack) op = REQ_ACK_RX;
         else if (roll < m.c_tick) op = REQ_TICK;
         else if (roll < m.c_tx) op = REQ_TX_SLOT;
         else op = 3'($urandom_range(REQ_SPARE_A, REQ_SPARE_C));
         ack = ($urandom_range(0, 9) < 3) ? ACK_STOP : ACK_GO;
         offer_item(op, HANDLE_W'($urandom), ack, 1'b0, '0);
      end
   endtask

   // receiver side: random stalls plus one long hold-off to back the node up
   initial begin
      while (reset) @(posedge clock);
      rsp_tready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!pressure_done && replies_seen >= PRESSURE_AFTER) begin
            pressure_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (rx_jitter && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : reply_check
      node_reply_type want;
      node_reply_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = out_kind_type'(rsp_tuser);
         got.handle = rsp_tdata[HANDLE_W-1:0];
         got.fill = rsp_tdata[HANDLE_W +: FILL_W];
         got.may_send = rsp_tdata[HANDLE_W + FILL_W];
         got.may_receive = rsp_tdata[HANDLE_W + FILL_W + 1];
         replies_seen++;
         if (awaited_replies.size() == 0) begin
            $error("unexpected item out_kind %0d", rsp_tuser);
            fault_count++;
         end else begin
            want = awaited_replies.pop_front();
            if (got.kind !== want.kind) begin
               $error("out_kind expected %0d actual %0d", want.kind, rsp_tuser);
               fault_count++;
            end
            if (got.handle !== want.handle) begin
               $error("out_handle expected %h actual %h", want.handle, got.handle);
               fault_count++;
            end
            if (got.fill !== want.fill) begin
               $error("queue_fill expected %0d actual %0d", want.fill, got.fill);
               fault_count++;
            end
            if (got.may_send !== want.may_send) begin
               $error("may_send expected %b actual %b", want.may_send, got.may_send);
               fault_count++;
            end
            if (got.may_receive !== want.may_receive) begin
               $error("may_receive expected %b actual %b", want.may_receive, got.may_receive);
               fault_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) quiet = 0;
         else quiet++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      directed_plan = '{
         typed_row(REQ_TX_SLOT, 16'h0000, ACK_GO, OUT_NONE, 16'h0000, 0, 1'b1, 1'b1),
         typed_row(REQ_ENQUEUE, 16'h0000, ACK_GO, OUT_ENQUEUED, 16'h0000, 1, 1'b1, 1'b1),
         typed_row(REQ_ENQUEUE, 16'hFFFF, ACK_STOP, OUT_ENQUEUED, 16'h0000, 2, 1'b1, 1'b1),
         typed_row(REQ_TX_SLOT, 16'hFFFF, ACK_STOP, OUT_DATA, 16'h0000, 1, 1'b0, 1'b1),
         typed_row(REQ_TX_SLOT, 16'h0000, ACK_GO, OUT_NONE, 16'h0000, 1, 1'b0, 1'b1),
         typed_row(REQ_ACK_RX, 16'h0000, ACK_GO, OUT_NONE, 16'h0000, 1, 1'b1, 1'b1),
         typed_row(REQ_TX_SLOT, 16'h0000, ACK_GO, OUT_DATA, 16'hFFFF, 0, 1'b0, 1'b1),
         typed_row(REQ_ACK_RX, 16'hFFFF, ACK_STOP, OUT_NONE, 16'h0000, 0, 1'b0, 1'b1),
         typed_row(REQ_ACK_RX, 16'h0000, ACK_GO, OUT_NONE, 16'h0000, 0, 1'b1, 1'b1),
         // short resume delay so the stop can be run out
         csr_row(CSR_RESUME_DELAY, 16'h0004),
         typed_row(REQ_DATA_RX, 16'h0000, ACK_GO, OUT_GO, 16'h0000, 0, 1'b1, 1'b1),
         typed_row(REQ_DATA_RX, 16'hFFFF, ACK_STOP, OUT_STOP, 16'h0000, 0, 1'b1, 1'b0),
         typed_row(REQ_DATA_RX, 16'h0000, ACK_GO, OUT_DISCARD, 16'h0000, 0, 1'b1, 1'b0),
         typed_row(REQ_TICK, 16'h0000, ACK_GO, OUT_NONE, 16'h0000, 0, 1'b1, 1'b0),
         typed_row(REQ_SPARE_A, 16'hFFFF, ACK_STOP, OUT_NONE, 16'h0000, 0, 1'b1, 1'b0),
         typed_row(REQ_SPARE_B, 16'h5A5A, ACK_GO, OUT_NONE, 16'h0000, 0, 1'b1, 1'b0),
         typed_row(REQ_SPARE_C, 16'hA5A5, ACK_STOP, OUT_NONE, 16'h0000, 0, 1'b1, 1'b0),
         // run the delay down to its last two ticks
         item_row(REQ_TICK, 16'h0000, ACK_GO, 1),
         typed_row(REQ_TICK, 16'h0000, ACK_GO, OUT_NONE, 16'h0000, 0, 1'b1, 1'b0),
         typed_row(REQ_TICK, 16'h0000, ACK_GO, OUT_GO, 16'h0000, 0, 1'b1, 1'b1),
         typed_row(REQ_TICK, 16'h0000, ACK_GO, OUT_NONE, 16'h0000, 0, 1'b1, 1'b1),
         item_row(REQ_ENQUEUE, 16'h1230, ACK_GO, DEPTH),
         typed_row(REQ_ENQUEUE, 16'hBEEF, ACK_GO, OUT_FULL, 16'h0000, DEPTH, 1'b1, 1'b1),
         item_row(REQ_TX_SLOT, 16'h0000, ACK_GO, 1),
         // zero stop count and zero delay
         csr_row(CSR_STOP_COUNT, 16'h0000),
         csr_row(CSR_RESUME_DELAY, 16'h0000),
         typed_row(REQ_DATA_RX, 16'h0000, ACK_GO, OUT_STOP, 16'h0000, 15, 1'b0, 1'b0),
         typed_row(REQ_TICK, 16'h0000, ACK_GO, OUT_GO, 16'h0000, 15, 1'b0, 1'b1)
      };
      random_phases = '{
         '{1, 1, 30, 25, 50, 65, 80, 97, 1'b1},
         '{4, 12, 40, 25, 50, 62, 82, 97, 1'b1},
         '{0, 0, 20, 20, 50, 65, 80, 97, 1'b1},
         '{255, 2, 320, 3, 88, 90, 97, 99, 1'b1},
         '{1, 65535, 20, 25, 55, 70, 80, 97, 1'b0}
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_csr) begin
            write_reg(directed_plan[i].reg_index, directed_plan[i].handle);
         end else begin
            for (int k = 0; k < directed_plan[i].reps; k++) begin
               offer_item(directed_plan[i].op, directed_plan[i].handle + HANDLE_W'(k),
                          directed_plan[i].ack, directed_plan[i].typed,
                          directed_plan[i].reply);
            end
         end
      end
      foreach (random_phases[p]) run_phase(random_phases[p]);
      req_tvalid <= 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> go_stop_flow_control_node_unit.f
design/gsfc_pkg.sv
design/go_stop_flow_control_node_unit.sv
sim/go_stop_flow_control_node_unit_tb.sv
